/* rtl/deq_pkg.sv */
// Package with the shared constants and request/status codes of the deque unit.
`default_nettype none

package deq_pkg;

    // Default geometry of the store.
    localparam int DEPTH_DEFAULT      = 128;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    // Fixed field widths of the request and result beats.
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } deq_state_t;

endpackage

`default_nettype wire

/* rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: request sequencing, pointers and result register.
`default_nettype none

// Bounded double-ended queue held in a circular store of DEPTH entries with a
// head pointer and an item count. Each request beat (kind, value) pushes at the
// front or rear or pops from the front or rear, and yields exactly one result
// beat (popped_value, status, occupancy). A push or a rejected request (push
// when full, pop when empty) is answered from the idle state; a successful pop
// passes through the read state, because the store's read port is registered.
// The result sits in an output register, so a new request is taken in the
// same cycle the previous result is drained. Rejected requests leave the
// queue unchanged. The store is not cleared at reset and needs no init pass.
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [deq_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [deq_pkg::VALUE_W-1:0] popped_value,
    output logic      [deq_pkg::STATUS_W-1:0] status,
    output logic      [deq_pkg::OCC_W-1:0]    occupancy
);

    import deq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Sequencer, pointer and result registers.
    deq_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    popped_reg, popped_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    // Store port signals.
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [ITEM_WIDTH-1:0] rd_data;

    // Address arithmetic.
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [IDX_W-1:0]      head_dec;
    logic [IDX_W-1:0]      head_inc;
    logic [SUM_W-1:0]      rear_sum;
    logic [SUM_W-1:0]      last_sum;
    logic [IDX_W-1:0]      rear_idx;
    logic [IDX_W-1:0]      last_idx;
    logic signed [63:0]    value_ext;
    logic signed [ITEM_WIDTH-1:0] rd_item;
    logic signed [63:0]    rd_ext;

    deq_store #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A request is taken only when idle and the result register is free or draining.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Circular neighbors of the head and the rear positions.
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rear_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum = rear_sum - 1'b1;
    assign rear_idx = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(rear_sum);
    assign last_idx = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(last_sum);

    // Item width conversion on the way in and out of the store.
    assign value_ext = 64'(value);
    assign wr_data   = ITEM_WIDTH'(value_ext);
    assign rd_item   = rd_data;
    assign rd_ext    = 64'(rd_item);

    // Next-state logic for the sequencer, pointers and result register.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        wr_en          = 1'b0;
        wr_addr        = rear_idx;
        rd_en          = 1'b0;
        rd_addr        = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR)
                    begin
                        popped_next    = '0;
                        out_valid_next = 1'b1;
                        if (is_full)
                        begin
                            status_next = STATUS_FULL;
                            occ_next    = OCC_W'(count_reg);
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = STATUS_OK;
                            occ_next    = OCC_W'(count_reg + 1'b1);
                            if (kind == KIND_PUSH_FRONT)
                            begin
                                wr_addr   = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (is_empty)
                    begin
                        popped_next    = '0;
                        status_next    = STATUS_EMPTY;
                        occ_next       = OCC_W'(count_reg);
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        // Successful pop: read now, the result is taken from the store in the read state.
                        rd_en       = 1'b1;
                        count_next  = count_reg - 1'b1;
                        status_next = STATUS_OK;
                        occ_next    = OCC_W'(count_reg - 1'b1);
                        state_next  = ST_READ;
                        if (kind == KIND_POP_FRONT)
                        begin
                            rd_addr   = head_reg;
                            head_next = head_inc;
                        end
                        else
                        begin
                            rd_addr = last_idx;
                        end
                    end
                end
            end
            ST_READ:
            begin
                popped_next    = VALUE_W'(rd_ext);
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule

`default_nettype wire

/* rtl/deq_store.sv */
// Item store of the deque: one write port and one registered read port.
`default_nettype none

module deq_store #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = deq_pkg::ITEM_WIDTH_DEFAULT,
    parameter int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire logic [ITEM_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output logic      [ITEM_WIDTH-1:0] rd_data
);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;

    // Synchronous write and registered read; contents are not reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* test/double_ended_queue_unit_tb.sv */
// Testbench for the double-ended queue unit: directed table plus biased random traffic.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
    import deq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int ITEM_WIDTH = ITEM_WIDTH_DEFAULT;
    localparam int RANDOM_PER_PHASE = 122;

    // One result beat as the unit reports it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] popped;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } deq_result_t;

    // One row of the directed table; pushes of a repeated row add the repeat index.
    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        int                        reps;
        bit                        typed;
        deq_result_t               typed_res;
    } request_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [KIND_W-1:0]           kind = KIND_PUSH_FRONT;
    logic signed [VALUE_W-1:0]   value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [VALUE_W-1:0]   popped_value;
    logic [STATUS_W-1:0]         status;
    logic [OCC_W-1:0]            occupancy;

    // Shadow copy of the deque contents and pointers.
    logic [ITEM_WIDTH-1:0]       shadow_items [DEPTH];
    int                          shadow_head = 0;
    int                          shadow_count = 0;

    deq_result_t                 awaited_results [$];
    request_row_t                request_table [$];
    int                          mismatch_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;

    double_ended_queue_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow deque and return the result it must produce.
    function automatic deq_result_t apply_request(input logic [KIND_W-1:0] k,
                                                  input logic signed [VALUE_W-1:0] v);
        deq_result_t res;
        int slot;
        res.popped = '0;
        res.status = STATUS_OK;
        if (k == KIND_PUSH_FRONT || k == KIND_PUSH_REAR)
        begin
            if (shadow_count >= DEPTH)
                res.status = STATUS_FULL;
            else if (k == KIND_PUSH_FRONT)
            begin
                shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                shadow_items[shadow_head] = v[ITEM_WIDTH-1:0];
                shadow_count++;
            end
            else
            begin
                slot = (shadow_head + shadow_count) % DEPTH;
                shadow_items[slot] = v[ITEM_WIDTH-1:0];
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                res.status = STATUS_EMPTY;
            else if (k == KIND_POP_FRONT)
            begin
                res.popped = $signed(shadow_items[shadow_head]);
                shadow_head = (shadow_head + 1) % DEPTH;
                shadow_count--;
            end
            else
            begin
                slot = (shadow_head + shadow_count - 1) % DEPTH;
                res.popped = $signed(shadow_items[slot]);
                shadow_count--;
            end
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v,
                           input int reps, input bit typed,
                           input logic signed [VALUE_W-1:0] exp_popped,
                           input logic [STATUS_W-1:0] exp_status,
                           input logic [OCC_W-1:0] exp_occ);
        request_row_t row;
        row.kind = k;
        row.value = v;
        row.reps = reps;
        row.typed = typed;
        row.typed_res.popped = exp_popped;
        row.typed_res.status = exp_status;
        row.typed_res.occupancy = exp_occ;
        request_table.push_back(row);
    endtask

    // Offer one request beat, wait for it to be taken, then record its expected result.
    task automatic send_request(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v,
                                input bit typed, input deq_result_t typed_res);
        deq_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_request(k, v);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid and hold off until every outstanding result has drained.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: check each result beat against the oldest expectation, then pick the next ready.
    always @(posedge clk)
    begin
        deq_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("Result beat with nothing expected: popped_value %0d status %0d",
                       popped_value, status);
                mismatch_count++;
            end
            else
            begin
                exp_res = awaited_results.pop_front();
                if (popped_value !== exp_res.popped)
                begin
                    $error("popped_value: expected %0d, got %0d", exp_res.popped, popped_value);
                    mismatch_count++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    mismatch_count++;
                end
                if (occupancy !== exp_res.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", exp_res.occupancy, occupancy);
                    mismatch_count++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stimulus: reset, the directed table, then three random phases with different idling.
    initial
    begin : stimulus
        deq_result_t no_res;
        logic [KIND_W-1:0] k;
        logic signed [VALUE_W-1:0] v;
        bit filling;
        int phase;
        no_res = '0;
        filling = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pops, extreme values from both ends, a fill past full and a wrapping drain.
        add_row(KIND_POP_FRONT, 32'h3c3c_3c3c, 1, 1, 0, STATUS_EMPTY, 8'd0);
        add_row(KIND_POP_REAR, 32'hc3c3_c3c3, 1, 1, 0, STATUS_EMPTY, 8'd0);
        add_row(KIND_PUSH_FRONT, 32'h7fff_ffff, 1, 1, 0, STATUS_OK, 8'd1);
        add_row(KIND_PUSH_REAR, 32'h8000_0000, 1, 1, 0, STATUS_OK, 8'd2);
        add_row(KIND_PUSH_FRONT, 32'hffff_ffff, 1, 1, 0, STATUS_OK, 8'd3);
        add_row(KIND_PUSH_REAR, 32'h0000_0000, 1, 1, 0, STATUS_OK, 8'd4);
        add_row(KIND_POP_FRONT, 32'h0000_0000, 1, 1, 32'hffff_ffff, STATUS_OK, 8'd3);
        add_row(KIND_POP_REAR, 32'hffff_ffff, 1, 1, 32'h0000_0000, STATUS_OK, 8'd2);
        add_row(KIND_POP_FRONT, 32'h1234_5678, 1, 1, 32'h7fff_ffff, STATUS_OK, 8'd1);
        add_row(KIND_POP_REAR, 32'h1234_5678, 1, 1, 32'h8000_0000, STATUS_OK, 8'd0);
        add_row(KIND_POP_FRONT, 32'h5a5a_5a5a, 1, 1, 0, STATUS_EMPTY, 8'd0);
        add_row(KIND_PUSH_REAR, 32'h5555_5500, DEPTH, 0, 0, STATUS_OK, 8'd0);
        add_row(KIND_PUSH_FRONT, 32'haaaa_aaaa, 1, 1, 0, STATUS_FULL, 8'd128);
        add_row(KIND_PUSH_REAR, 32'h5555_5555, 1, 1, 0, STATUS_FULL, 8'd128);
        add_row(KIND_POP_FRONT, 32'h0000_0000, 1, 0, 0, STATUS_OK, 8'd0);
        add_row(KIND_PUSH_FRONT, 32'hdead_0001, 1, 0, 0, STATUS_OK, 8'd0);
        add_row(KIND_PUSH_REAR, 32'h0bad_0002, 1, 1, 0, STATUS_FULL, 8'd128);
        add_row(KIND_POP_REAR, 32'h0000_0000, DEPTH, 0, 0, STATUS_OK, 8'd0);
        add_row(KIND_POP_REAR, 32'h7fff_ffff, 1, 1, 0, STATUS_EMPTY, 8'd0);
        add_row(KIND_PUSH_FRONT, 32'h0f0f_0000, 5, 0, 0, STATUS_OK, 8'd0);
        add_row(KIND_POP_FRONT, 32'h0000_0000, 6, 0, 0, STATUS_OK, 8'd0);

        send_idle_pct = 29;
        recv_idle_pct = 68;
        foreach (request_table[i])
        begin
            for (int rep = 0; rep < request_table[i].reps; rep++)
            begin
                v = request_table[i].value;
                if (request_table[i].kind == KIND_PUSH_FRONT ||
                    request_table[i].kind == KIND_PUSH_REAR)
                    v = v + rep;
                send_request(request_table[i].kind, v, request_table[i].typed,
                             request_table[i].typed_res);
            end
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 29 : 0;
            repeat (RANDOM_PER_PHASE)
            begin
                // Swing between filling and draining so both full and empty are reached.
                if (shadow_count == DEPTH && $urandom_range(0, 3) == 0)
                    filling = 1'b0;
                else if (shadow_count == 0 && $urandom_range(0, 3) == 0)
                    filling = 1'b1;
                if ($urandom_range(0, 99) < 15)
                    k = KIND_W'($urandom_range(0, 3));
                else if ($urandom_range(0, 99) < (filling ? 85 : 15))
                    k = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
                else
                    k = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
                case ($urandom_range(0, 15))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0000_0000;
                    default: v = $urandom;
                endcase
                send_request(k, v, 1'b0, no_res);
            end
            // The sender goes quiet once until the unit has returned every result.
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
